@@ hw/rtl/mal_pkg.sv @@
// Package for the multilayer audio looper: item structs, mode, action and
// sequencer state codes. No dependencies.
package mal_pkg;

  localparam int SAMPLE_BITS = 16;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_REC  = 3'd1,
    MODE_PLAY = 3'd2,
    MODE_DUB  = 3'd3,
    MODE_STOP = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MODE = 2'd1,
    ACT_UNDO = 2'd2,
    ACT_REDO = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAYER,
    ST_DIV,
    ST_RD,
    ST_ACC,
    ST_PHEAD,
    ST_PDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] in_sample;
    logic [2:0]         new_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic [2:0]         mode_now;
    logic [3:0]         layers_active;
    logic [3:0]         layers_redoable;
    logic [16:0]        base_length;
    logic [15:0]        play_position;
    logic               dropped;
  } out_item_t;

endpackage

@@ hw/rtl/mal_rem.sv @@
// Restoring remainder unit, one dividend bit per cycle.
// Standalone; used by the looper top level for all modulo operations.
module mal_rem #(
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;

  assign trial = {rem, quo[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= DW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> busy || done) else $error("remainder unit lost its run");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done || $past(start, 1) == 1'b0) else $error("done held");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

endmodule

@@ hw/rtl/multilayer_audio_looper.sv @@
// Top level of the multilayer audio looper: sequencer, layer stacks, sample memory.
// Uses mal_pkg and mal_rem.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready   | mal_pkg::in_item_t
//  out     | out | out_valid/out_ready | mal_pkg::out_item_t
//
// Mode requests, undo, redo and non-mixing ticks go straight from ST_IDLE to ST_DONE.
// A mixing tick runs ST_LAYER, ST_DIV, ST_RD, ST_ACC per layer, then ST_PHEAD, ST_PDIV;
// its pace is set by the shared remainder unit and the single sample memory read port.
// Reset is synchronous; the sample memory is not cleared.
// in_ready drops while an item is in work; a waiting result holds the sequencer.
module multilayer_audio_looper #(
  parameter int MAX_LAYERS   = 8,
  parameter int MAX_LOOP_LEN = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mal_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mal_pkg::out_item_t  out_item
);

  localparam int SB = mal_pkg::SAMPLE_BITS;
  localparam int SW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int LW = $clog2(MAX_LOOP_LEN + 1);
  localparam int PW = $clog2(MAX_LOOP_LEN);
  localparam int AW = $clog2(MAX_LAYERS * MAX_LOOP_LEN);
  localparam int MW = SB + CW + 1;
  localparam int DEPTH = MAX_LAYERS * MAX_LOOP_LEN;

  mal_pkg::state_t state, state_next;
  mal_pkg::mode_t  mode;

  logic [LW-1:0]          slot_len [MAX_LAYERS];
  logic [MAX_LAYERS-1:0]  slot_free;
  logic [SW-1:0]          pstack [MAX_LAYERS];
  logic [SW-1:0]          rstack [MAX_LAYERS];
  logic [CW-1:0]          pcount;
  logic [CW-1:0]          rcount;
  logic [PW-1:0]          playhead;
  logic signed [MW-1:0]   mix;
  logic                   dropped;
  logic [CW-1:0]          k;
  logic [AW-1:0]          rd_addr;
  logic signed [SB-1:0]   rd_data;
  logic signed [SB-1:0]   mem [DEPTH];

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic                   item_drop;

  logic [SW-1:0]          top_slot;
  logic [SW-1:0]          k_slot;
  logic [LW-1:0]          top_len;
  logic [LW-1:0]          k_len;
  logic [LW-1:0]          base_len;
  logic                   free_any;
  logic [SW-1:0]          free_idx;
  logic                   is_tick;

  logic                   div_start;
  logic [LW-1:0]          div_dividend;
  logic [LW-1:0]          div_divisor;
  logic                   div_done;
  logic [LW-1:0]          div_rem;

  mal_rem #(.DW(LW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_ready = (state == mal_pkg::ST_IDLE);
  assign is_tick  = (in_item.action == mal_pkg::ACT_TICK);

  always_comb begin
    top_slot = pstack[SW'(pcount - 1'b1)];
    k_slot   = pstack[k[SW-1:0]];
    top_len  = slot_len[top_slot];
    k_len    = slot_len[k_slot];
    base_len = (pcount != '0) ? slot_len[pstack[0]] : '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
      if (slot_free[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mal_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (is_tick && (mode == mal_pkg::MODE_PLAY || mode == mal_pkg::MODE_DUB)) begin
            state_next = mal_pkg::ST_LAYER;
          end else begin
            state_next = mal_pkg::ST_DONE;
          end
        end
      end
      mal_pkg::ST_LAYER: begin
        if (k >= pcount) begin
          state_next = mal_pkg::ST_PHEAD;
        end else if (k_len != '0) begin
          state_next = mal_pkg::ST_DIV;
        end
      end
      mal_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = mal_pkg::ST_RD;
        end
      end
      mal_pkg::ST_RD:  state_next = mal_pkg::ST_ACC;
      mal_pkg::ST_ACC: state_next = mal_pkg::ST_LAYER;
      mal_pkg::ST_PHEAD: begin
        if (base_len != '0) begin
          state_next = mal_pkg::ST_PDIV;
        end else begin
          state_next = mal_pkg::ST_DONE;
        end
      end
      mal_pkg::ST_PDIV: begin
        if (div_done) begin
          state_next = mal_pkg::ST_DONE;
        end
      end
      mal_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = mal_pkg::ST_IDLE;
        end
      end
      default: state_next = mal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = LW'(playhead);
    div_divisor  = k_len;
    wr_en        = 1'b0;
    wr_addr      = AW'(top_slot) * AW'(MAX_LOOP_LEN) + AW'(top_len);
    unique case (state)
      mal_pkg::ST_LAYER: begin
        div_start = (k < pcount) && (k_len != '0);
      end
      mal_pkg::ST_PHEAD: begin
        div_start    = (base_len != '0);
        div_dividend = LW'(playhead) + LW'(1);
        div_divisor  = base_len;
      end
      mal_pkg::ST_IDLE: begin
        wr_en = in_valid && is_tick && (pcount != '0) &&
                (mode == mal_pkg::MODE_REC || mode == mal_pkg::MODE_DUB) &&
                (top_len < LW'(MAX_LOOP_LEN));
      end
      default: ;
    endcase
    item_drop = 1'b0;
    if (is_tick) begin
      item_drop = (mode == mal_pkg::MODE_REC || mode == mal_pkg::MODE_DUB) && !wr_en;
    end else if (in_item.action == mal_pkg::ACT_MODE && mode == mal_pkg::MODE_PLAY &&
                 in_item.new_mode == mal_pkg::MODE_DUB) begin
      item_drop = !(pcount < CW'(MAX_LAYERS) && free_any);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.in_sample;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mal_pkg::ST_IDLE;
      mode      <= mal_pkg::MODE_IDLE;
      slot_free <= '1;
      pcount    <= '0;
      rcount    <= '0;
      playhead  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_LAYERS; i++) begin
        slot_len[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == mal_pkg::ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mal_pkg::ST_IDLE: begin
          if (in_valid) begin
            dropped <= item_drop;
            k       <= '0;
            if (is_tick && mode == mal_pkg::MODE_DUB) begin
              mix <= MW'(in_item.in_sample);
            end else begin
              mix <= '0;
            end
            unique case (in_item.action)
              mal_pkg::ACT_MODE: begin
                if (in_item.new_mode <= mal_pkg::MODE_STOP) begin
                  if (mode == mal_pkg::MODE_IDLE && in_item.new_mode == mal_pkg::MODE_REC) begin
                    slot_free    <= {{(MAX_LAYERS-1){1'b1}}, 1'b0};
                    pstack[0]    <= '0;
                    slot_len[0]  <= '0;
                    pcount       <= CW'(1);
                    rcount       <= '0;
                    playhead     <= '0;
                    mode         <= mal_pkg::mode_t'(in_item.new_mode);
                  end else if (mode == mal_pkg::MODE_PLAY &&
                               in_item.new_mode == mal_pkg::MODE_DUB) begin
                    if (pcount < CW'(MAX_LAYERS) && free_any) begin
                      slot_free[free_idx] <= 1'b0;
                      slot_len[free_idx]  <= '0;
                      pstack[pcount[SW-1:0]] <= free_idx;
                      pcount   <= pcount + 1'b1;
                      playhead <= '0;
                      mode     <= mal_pkg::MODE_DUB;
                    end
                  end else begin
                    mode <= mal_pkg::mode_t'(in_item.new_mode);
                  end
                end
              end
              mal_pkg::ACT_UNDO: begin
                if (pcount != '0 && rcount < CW'(MAX_LAYERS)) begin
                  rstack[rcount[SW-1:0]] <= top_slot;
                  rcount <= rcount + 1'b1;
                  pcount <= pcount - 1'b1;
                end
              end
              mal_pkg::ACT_REDO: begin
                if (rcount != '0 && pcount < CW'(MAX_LAYERS)) begin
                  pstack[pcount[SW-1:0]] <= rstack[SW'(rcount - 1'b1)];
                  pcount <= pcount + 1'b1;
                  rcount <= rcount - 1'b1;
                end
              end
              default: begin
                if (wr_en) begin
                  slot_len[top_slot] <= top_len + 1'b1;
                end
              end
            endcase
          end
        end
        mal_pkg::ST_LAYER: begin
          if (k < pcount && k_len == '0) begin
            k <= k + 1'b1;
          end
        end
        mal_pkg::ST_DIV: begin
          if (div_done) begin
            rd_addr <= AW'(k_slot) * AW'(MAX_LOOP_LEN) + AW'(div_rem);
          end
        end
        mal_pkg::ST_ACC: begin
          mix <= mix + MW'(rd_data);
          k   <= k + 1'b1;
        end
        mal_pkg::ST_PDIV: begin
          if (div_done) begin
            playhead <= PW'(div_rem);
          end
        end
        default: ;
      endcase
    end
  end

  logic signed [SB-1:0] mix_sat;
  logic [31:0]          w_pcount;
  logic [31:0]          w_rcount;
  logic [31:0]          w_base;
  logic [31:0]          w_head;

  always_comb begin
    if (mix > MW'((1 << (SB - 1)) - 1)) begin
      mix_sat = SB'((1 << (SB - 1)) - 1);
    end else if (mix < -MW'(1 << (SB - 1))) begin
      mix_sat = SB'(-(1 << (SB - 1)));
    end else begin
      mix_sat = mix[SB-1:0];
    end
    w_pcount = 32'(pcount);
    w_rcount = 32'(rcount);
    w_base   = 32'(base_len);
    w_head   = 32'(playhead);
  end

  always_ff @(posedge clk) begin
    if (state == mal_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_item.out_sample      <= mix_sat;
      out_item.mode_now        <= mode;
      out_item.layers_active   <= w_pcount[3:0];
      out_item.layers_redoable <= w_rcount[3:0];
      out_item.base_length     <= w_base[16:0];
      out_item.play_position   <= w_head[15:0];
      out_item.dropped         <= dropped;
    end
  end

  a_stack_total: assert property (@(posedge clk) disable iff (rst)
    32'(pcount) + 32'(rcount) <= MAX_LAYERS) else $error("layer stacks overfull");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != mal_pkg::ST_IDLE) else $error("item not taken up");
  a_done_fires: assert property (@(posedge clk) disable iff (rst)
    state == mal_pkg::ST_DONE && state_next == mal_pkg::ST_IDLE |=> out_valid)
    else $error("result lost");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == mal_pkg::ST_DIV || state == mal_pkg::ST_PDIV)
    else $error("stray remainder result");

endmodule
